>>> hdl/ftrk_pkg.sv
package ftrk_pkg;

  localparam int FlowEntries = 256;
  localparam int IdxW = $clog2(FlowEntries);
  localparam int CntW = $clog2(FlowEntries + 1);

  localparam int InW = 4 + 8 + 32 + 32 + 16 + 16 + 32 + 4 + 16 + 16;
  localparam int InBytesW = ((InW + 7) / 8) * 8;
  localparam int OutW = 3 + 2 + 1 + 17 + 9 + 9 + 32 * 6;
  localparam int OutBytesW = ((OutW + 7) / 8) * 8;

  localparam logic [7:0] ProtoTcp = 8'd6;
  localparam logic [7:0] ProtoUdp = 8'd17;

  localparam logic [2:0] ClassBadIp = 3'd0;
  localparam logic [2:0] ClassOther = 3'd1;
  localparam logic [2:0] ClassTcp = 3'd2;
  localparam logic [2:0] ClassTcpBad = 3'd3;
  localparam logic [2:0] ClassUdp = 3'd4;

  localparam logic [1:0] StatExisting = 2'd0;
  localparam logic [1:0] StatNew = 2'd1;
  localparam logic [1:0] StatFull = 2'd2;
  localparam logic [1:0] StatNa = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture input transaction
    logic rd;        // issue a table read at scan index
    logic scan_inc;  // advance scan index
    logic hit;       // record match at the previous read index
    logic upd_seq;   // write new sequence to hit entry
    logic insert;    // write new entry at used count
    logic finish;    // update counters and build result
  } ftrk_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic bad_ip;
    logic is_tcp;
    logic is_udp;
    logic tcp_bad;
    logic scan_done;  // scan index reached used count
    logic match;      // registered read data matches key
    logic seq_greater;
    logic full;
  } ftrk_stat_t;

endpackage

>>> hdl/tcp_udp_flow_tracker.sv
// Flow tracker for parsed IPv4 TCP/UDP headers.
// Slave channel s_axis carries one packet's header fields per transaction;
// master channel m_axis returns one result per packet with class, flow
// status, retransmission flag, payload length and the running counters.
// One packet is processed at a time. The linear search reads and compares
// one table entry at a time and stops at a match or after all stored flows
// of that protocol (up to 256). Bad IP headers, other protocols and empty
// tables skip the search and go straight to the result.
// s_axis_tready is high only while no packet is in progress, so a stalled
// m_axis receiver holds the result and stops input until it is taken.
// Reset clears the flow counts and all counters; table contents are not
// cleared, only entries below the flow count are ever read.
module tcp_udp_flow_tracker
  import ftrk_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // ip_header_words, protocol, src_addr, dst_addr, src_port, dst_port,
  // tcp_sequence, tcp_data_offset, ip_total_length, wire_length
  input  logic [InBytesW-1:0]  s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // packet_class, flow_status, retransmitted, payload_length, tcp_flow_count,
  // udp_flow_count, packet_count, tcp_packet_count, udp_packet_count,
  // tcp_byte_count, udp_byte_count, retransmission_count
  output logic [OutBytesW-1:0] m_axis_tdata
);

  ftrk_cmd_t      cmd;
  ftrk_stat_t     stat;
  logic [OutW-1:0] res;

  ftrk_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .stat_i(stat), .cmd_o(cmd)
  );

  ftrk_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .in_i(s_axis_tdata[InW-1:0]),
    .stat_o(stat), .res_o(res)
  );

  assign m_axis_tdata = {{(OutBytesW - OutW){1'b0}}, res};

endmodule

>>> hdl/ftrk_datapath.sv
module ftrk_datapath
  import ftrk_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ftrk_cmd_t            cmd_i,
  input  logic [InW-1:0]       in_i,
  output ftrk_stat_t           stat_o,
  output logic [OutW-1:0]      res_o
);

  logic [3:0]  ihl_q;
  logic [7:0]  proto_q;
  logic [31:0] src_q, dst_q, ports_q, seq_q;
  logic [3:0]  off_q;
  logic [15:0] tot_q, wire_q;

  logic [31:0] t_src_m [FlowEntries];
  logic [31:0] t_dst_m [FlowEntries];
  logic [31:0] t_prt_m [FlowEntries];
  logic [31:0] t_seq_m [FlowEntries];
  logic [31:0] u_src_m [FlowEntries];
  logic [31:0] u_dst_m [FlowEntries];
  logic [31:0] u_prt_m [FlowEntries];

  logic [31:0] rd_src_q, rd_dst_q, rd_prt_q, rd_seq_q;
  logic [CntW-1:0] scan_q, rd_idx_q;
  logic found_q;
  logic [CntW-1:0] tcp_used_q, udp_used_q;
  logic [31:0] pkt_q, tpkt_q, upkt_q, tbyte_q, ubyte_q, retx_cnt_q;
  logic [2:0]  cls_q;
  logic [1:0]  status_q;
  logic        retx_q;
  logic [16:0] pay_q;

  logic is_tcp, tcp_bad;
  logic [CntW-1:0] used;
  logic [IdxW-1:0] ins_idx;

  assign is_tcp = proto_q == ProtoTcp;
  assign tcp_bad = off_q < 4'd5;
  assign used = is_tcp ? tcp_used_q : udp_used_q;
  assign ins_idx = used[IdxW-1:0];

  assign stat_o.bad_ip = ihl_q < 4'd5;
  assign stat_o.is_tcp = is_tcp;
  assign stat_o.is_udp = proto_q == ProtoUdp;
  assign stat_o.tcp_bad = tcp_bad;
  assign stat_o.scan_done = scan_q >= used;
  assign stat_o.match = rd_src_q == src_q && rd_dst_q == dst_q && rd_prt_q == ports_q;
  assign stat_o.seq_greater = seq_q > rd_seq_q;
  assign stat_o.full = used >= CntW'(FlowEntries);

  // Table reads, registered.
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      if (is_tcp) begin
        rd_src_q <= t_src_m[scan_q[IdxW-1:0]];
        rd_dst_q <= t_dst_m[scan_q[IdxW-1:0]];
        rd_prt_q <= t_prt_m[scan_q[IdxW-1:0]];
        rd_seq_q <= t_seq_m[scan_q[IdxW-1:0]];
      end else begin
        rd_src_q <= u_src_m[scan_q[IdxW-1:0]];
        rd_dst_q <= u_dst_m[scan_q[IdxW-1:0]];
        rd_prt_q <= u_prt_m[scan_q[IdxW-1:0]];
        rd_seq_q <= '0;
      end
    end
  end

  // Table writes. The sequence update comes in the compare cycle, while
  // rd_idx_q still holds the index of the entry just read.
  always_ff @(posedge clk_i) begin
    if (cmd_i.upd_seq) begin
      t_seq_m[rd_idx_q[IdxW-1:0]] <= seq_q;
    end else if (cmd_i.insert && is_tcp) begin
      t_src_m[ins_idx] <= src_q;
      t_dst_m[ins_idx] <= dst_q;
      t_prt_m[ins_idx] <= ports_q;
      t_seq_m[ins_idx] <= seq_q;
    end
    if (cmd_i.insert && !is_tcp) begin
      u_src_m[ins_idx] <= src_q;
      u_dst_m[ins_idx] <= dst_q;
      u_prt_m[ins_idx] <= ports_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      {wire_q, tot_q, off_q, seq_q, ports_q[15:0], ports_q[31:16], dst_q, src_q,
       proto_q, ihl_q} <= in_i;
    end
  end

  logic [16:0] hdr_bytes;
  always_comb begin
    hdr_bytes = {11'd0, ihl_q, 2'b00} + (is_tcp ? {11'd0, off_q, 2'b00} : 17'd8);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= '0;
      rd_idx_q <= '0;
      found_q <= 1'b0;
      tcp_used_q <= '0;
      udp_used_q <= '0;
      pkt_q <= '0;
      tpkt_q <= '0;
      upkt_q <= '0;
      tbyte_q <= '0;
      ubyte_q <= '0;
      retx_cnt_q <= '0;
      cls_q <= ClassOther;
      status_q <= StatNa;
      retx_q <= 1'b0;
      pay_q <= '0;
    end else begin
      if (cmd_i.load) begin
        scan_q <= '0;
        found_q <= 1'b0;
        retx_q <= 1'b0;
      end
      if (cmd_i.rd) rd_idx_q <= scan_q;
      if (cmd_i.scan_inc) scan_q <= scan_q + CntW'(1);
      if (cmd_i.hit) begin
        found_q <= 1'b1;
        if (is_tcp && !stat_o.seq_greater) begin
          retx_q <= 1'b1;
          retx_cnt_q <= retx_cnt_q + 32'd1;
        end
      end
      if (cmd_i.insert) begin
        if (is_tcp) tcp_used_q <= tcp_used_q + CntW'(1);
        else udp_used_q <= udp_used_q + CntW'(1);
      end
      if (cmd_i.finish) begin
        pkt_q <= pkt_q + 32'd1;
        pay_q <= '0;
        if (stat_o.bad_ip) begin
          cls_q <= ClassBadIp;
          status_q <= StatNa;
        end else if (is_tcp) begin
          tpkt_q <= tpkt_q + 32'd1;
          if (tcp_bad) begin
            cls_q <= ClassTcpBad;
            status_q <= found_q ? StatExisting : StatNa;
          end else begin
            cls_q <= ClassTcp;
            tbyte_q <= tbyte_q + {16'd0, wire_q};
            pay_q <= {1'b0, tot_q} - hdr_bytes;
            status_q <= found_q ? StatExisting : (stat_o.full ? StatFull : StatNew);
          end
        end else if (stat_o.is_udp) begin
          cls_q <= ClassUdp;
          upkt_q <= upkt_q + 32'd1;
          ubyte_q <= ubyte_q + {16'd0, wire_q};
          pay_q <= {1'b0, tot_q} - hdr_bytes;
          status_q <= found_q ? StatExisting : (stat_o.full ? StatFull : StatNew);
        end else begin
          cls_q <= ClassOther;
          status_q <= StatNa;
        end
      end
    end
  end

  // Insert happens in the same cycle as finish, so full reflects the count before it.
  assign res_o = {retx_cnt_q, ubyte_q, tbyte_q, upkt_q, tpkt_q, pkt_q,
                  9'(udp_used_q), 9'(tcp_used_q), pay_q, retx_q, status_q, cls_q};

endmodule

>>> hdl/ftrk_ctrl.sv
module ftrk_ctrl
  import ftrk_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  ftrk_stat_t stat_i,
  output ftrk_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    StIdle, StDecode, StRead, StCheck, StFinish, StOut
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   found_q;

  assign in_ready_o = state_q == StIdle;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      StIdle:   cmd_o.load = in_valid_i;
      StRead: begin
        cmd_o.rd = 1'b1;
        cmd_o.scan_inc = 1'b1;
      end
      StCheck: begin
        cmd_o.hit = stat_i.match;
        cmd_o.upd_seq = stat_i.match && stat_i.is_tcp && stat_i.seq_greater;
      end
      StFinish: begin
        cmd_o.finish = 1'b1;
        // A flow that was found is never inserted again.
        cmd_o.insert = !found_q && !stat_i.bad_ip && !stat_i.full &&
                       ((stat_i.is_tcp && !stat_i.tcp_bad) || stat_i.is_udp);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      out_valid_q <= 1'b0;
      found_q <= 1'b0;
    end else begin
      unique case (state_q)
        StIdle: if (in_valid_i) begin
          state_q <= StDecode;
          found_q <= 1'b0;
        end
        StDecode: begin
          if (stat_i.bad_ip || (!stat_i.is_tcp && !stat_i.is_udp)) state_q <= StFinish;
          else if (stat_i.scan_done) state_q <= StFinish;
          else state_q <= StRead;
        end
        StRead: state_q <= StCheck;
        StCheck: begin
          if (stat_i.match) begin
            found_q <= 1'b1;
            state_q <= StFinish;
          end else if (stat_i.scan_done) state_q <= StFinish;
          else state_q <= StRead;
        end
        StFinish: begin
          state_q <= StOut;
          out_valid_q <= 1'b1;
        end
        StOut: begin
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule
